FILE: rtl/mas_pkg.sv
package mas_pkg;

    // Counter width for the per-sequence sample count (wraps modulo 2^16)
    localparam int CNT_W  = 16;
    localparam int MODE_W = 2;
    localparam int WLEN_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WLEN_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN = 1'd1;

    // Window placement codes; the unused code behaves as forward
    localparam logic [MODE_W-1:0] MODE_FWD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BWD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CTR = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_SUM   = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_LOAD  = 7'b1000000
    } t_state;

endpackage

FILE: rtl/mas_if.sv
interface mas_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_last;

    modport source (output valid, sample, is_last, input ready);
    modport sink   (input valid, sample, is_last, output ready);
endinterface

interface mas_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          empty_window;
    logic                          last_out;

    modport source (output valid, average, empty_window, last_out, input ready);
    modport sink   (input valid, average, empty_window, last_out, output ready);
endinterface

FILE: rtl/mas_ram.sv
module mas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/moving_average_smoother.sv
// Streaming moving-average smoother.
// Input channel i_in carries one sample and an is_last marker per request;
// output channel o_out carries one window mean per request, with an
// empty-window flag and a last_out marker on the final result of a sequence.
// Configuration (mode, window_len) is written through i_cfg_we/i_cfg_idx/
// i_cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce this. Each sample is accepted in the idle
// state and then checked for released results. Every released result then
// sums len terms (len = window length in samples) through the single ring
// read port and adder, then the restoring divider yields one quotient bit
// per cycle of the SUM_W-bit sum (SUM_W = SAMPLE_BITS + clog2(WINDOW_MAX)
// + 1, i.e. 22 at the defaults). An empty window skips both.
// A request carrying is_last releases every pending result and then
// restarts the sequence. i_in.ready is high only while the sequencer is idle.
// Results sit in an output register; the sequencer keeps working while one
// waits and stalls only when a second result is ready before the first
// is taken. Reset clears the sequence state, sets mode to forward and
// window_len to 1, and drops o_out.valid; the ring needs no clearing.
module moving_average_smoother
    import mas_pkg::*;
#(
    parameter int WINDOW_MAX  = 32,
    parameter int RING_DEPTH  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mas_in_if.sink                i_in,
    mas_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int OFS_W  = $clog2(WINDOW_MAX) + 3;
    localparam int AW     = $clog2(RING_DEPTH);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    t_state r_state, n_state;

    logic [MODE_W-1:0]  r_mode;
    logic [WLEN_W-1:0]  r_wlen;

    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_newest;
    logic [CNT_W-1:0]   r_seen;
    logic [LEN_W-1:0]   r_pending;
    logic               r_last;
    logic signed [SAMPLE_BITS-1:0] r_first;

    logic signed [OFS_W-1:0] r_back;
    logic [OFS_W-1:0]   r_red;
    logic [AW-1:0]      r_slot;
    logic [LEN_W-1:0]   r_cnt;
    logic               r_pvld;
    logic               r_use_first;
    logic signed [SUM_W-1:0] r_sum;

    logic [SUM_W-1:0]   r_dq;
    logic [LEN_W-1:0]   r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_neg;
    logic               r_empty;

    logic               r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_oavg;
    logic               r_oempty;
    logic               r_olast;

    logic in_acc;
    logic [SAMPLE_BITS-1:0] ram_rd;

    // Window geometry from the configuration
    logic [LEN_W-1:0] w, half, hi, len, lo_mag;
    logic             start;
    logic [OFS_W-1:0] back0;

    always_comb begin
        if (int'(r_wlen) > WINDOW_MAX) begin
            w = LEN_W'(WINDOW_MAX);
        end else begin
            w = LEN_W'(r_wlen);
        end
        half = w >> 1;
        unique case (r_mode)
            MODE_BWD: begin
                hi = '0;  len = w;  lo_mag = w;
            end
            MODE_CTR: begin
                hi = half;  len = half << 1;  lo_mag = half;
            end
            default: begin
                hi = w;  len = w;  lo_mag = '0;
            end
        endcase
    end

    assign start = (r_pending != '0) && (r_last || (r_pending >= hi));
    assign back0 = OFS_W'(r_pending) + OFS_W'(lo_mag) - OFS_W'(1);

    // Ring term selection
    logic [CNT_W-1:0] k;
    logic             use_first_now;
    logic signed [SAMPLE_BITS-1:0] term;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_mag;

    assign k             = r_seen - CNT_W'(1);
    assign use_first_now = (r_back > 0) && (CNT_W'($unsigned(r_back)) > k);
    assign term          = r_use_first ? r_first : $signed(ram_rd);
    assign sum_next      = r_sum + SUM_W'(term);
    assign sum_mag       = sum_next[SUM_W-1] ? $unsigned(-sum_next) : $unsigned(sum_next);

    // Restoring divide step
    logic [LEN_W:0] div_trial;
    logic           div_ge;
    logic [LEN_W:0] div_diff;

    assign div_trial = {r_rem, r_dq[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, len};
    assign div_diff  = div_trial - {1'b0, len};

    logic signed [SUM_W-1:0] quot_s;
    logic                    out_free;
    logic                    out_load;

    assign quot_s   = r_neg ? -$signed(r_dq) : $signed(r_dq);
    assign out_free = !r_ovalid || o_out.ready;
    assign out_load = (r_state == ST_LOAD) && out_free;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);

    assign o_out.valid        = r_ovalid;
    assign o_out.average      = r_oavg;
    assign o_out.empty_window = r_oempty;
    assign o_out.last_out     = r_olast;

    mas_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (in_acc),
        .i_waddr(r_wp),
        .i_wdata(i_in.sample),
        .i_raddr(r_slot),
        .o_rdata(ram_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!start) begin
                    n_state = ST_IDLE;
                end else if (len == '0) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP:  if (r_red < OFS_W'(RING_DEPTH) || int'(r_red) < RING_DEPTH) begin
                n_state = ST_SUM;
            end
            ST_SUM:   if (r_cnt == LEN_W'(1)) begin
                n_state = ST_TAIL;
            end
            ST_TAIL:  n_state = ST_DIV;
            ST_DIV:   if (r_dcnt == DCNT_W'(1)) begin
                n_state = ST_LOAD;
            end
            ST_LOAD:  if (out_free) begin
                n_state = ST_CHECK;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= MODE_FWD;
            r_wlen    <= WLEN_W'(1);
            r_wp      <= '0;
            r_newest  <= '0;
            r_seen    <= '0;
            r_pending <= '0;
            r_last    <= 1'b0;
            r_first   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_WLEN: r_wlen <= i_cfg_data;
                    default:  ;
                endcase
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_newest  <= r_wp;
                        r_wp      <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                        r_seen    <= r_seen + CNT_W'(1);
                        r_pending <= r_pending + LEN_W'(1);
                        r_last    <= i_in.is_last;
                        if (r_seen == '0) begin
                            r_first <= i_in.sample;
                        end
                    end
                end
                ST_CHECK: begin
                    if (!start) begin
                        // restart the sequence after the final flush
                        if (r_last) begin
                            r_first   <= '0;
                            r_wp      <= '0;
                            r_seen    <= '0;
                            r_pending <= '0;
                            r_last    <= 1'b0;
                        end
                    end else begin
                        r_back      <= $signed(back0);
                        r_red       <= back0;
                        r_cnt       <= len;
                        r_sum       <= '0;
                        r_pvld      <= 1'b0;
                        r_use_first <= 1'b0;
                        r_dq        <= '0;
                        r_neg       <= 1'b0;
                        r_empty     <= (len == '0);
                    end
                end
                ST_PREP: begin
                    if (int'(r_red) >= RING_DEPTH) begin
                        r_red <= r_red - OFS_W'(RING_DEPTH);
                    end else if (r_newest >= AW'(r_red)) begin
                        r_slot <= r_newest - AW'(r_red);
                    end else begin
                        r_slot <= r_newest + AW'(RING_DEPTH) - AW'(r_red);
                    end
                end
                ST_SUM: begin
                    if (r_pvld) begin
                        r_sum <= sum_next;
                    end
                    r_pvld      <= 1'b1;
                    r_use_first <= use_first_now;
                    // positions past the newest sample stay on the newest slot
                    if (r_back > 0) begin
                        r_slot <= (r_slot == AW'(RING_DEPTH - 1)) ? '0 : r_slot + AW'(1);
                    end
                    r_back <= r_back - OFS_W'(1);
                    r_cnt  <= r_cnt - LEN_W'(1);
                end
                ST_TAIL: begin
                    r_neg  <= sum_next[SUM_W-1];
                    r_dq   <= sum_mag;
                    r_rem  <= '0;
                    r_dcnt <= DCNT_W'(SUM_W);
                end
                ST_DIV: begin
                    if (div_ge) begin
                        r_rem <= div_diff[LEN_W-1:0];
                    end else begin
                        r_rem <= div_trial[LEN_W-1:0];
                    end
                    r_dq   <= {r_dq[SUM_W-2:0], div_ge};
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                end
                ST_LOAD: begin
                    if (out_free) begin
                        r_oavg    <= quot_s[SAMPLE_BITS-1:0];
                        r_oempty  <= r_empty;
                        r_olast   <= r_last && (r_pending == LEN_W'(1));
                        r_pending <= r_pending - LEN_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/mas_checker.sv
module mas_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_out_empty,
    input logic [SAMPLE_BITS-1:0] i_out_avg
);
    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_reset_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // an accepted request always passes through the check state before the next is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted on back-to-back cycles");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_empty |-> i_out_avg == '0)
        else $error("empty window with nonzero average");
endmodule

bind moving_average_smoother mas_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_mas_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_empty(o_out.empty_window),
    .i_out_avg  (o_out.average)
);
